### hdl/tswo_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp wrap offset mapper package
// Shared request, state and result types, status codes and scale constants.
// ----------------------------------------------------------------------------
package tswo_pkg;

    localparam int unsigned DEV_W  = 32;
    localparam int unsigned NS_W   = 64;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned EXT_MS_W = 44;

    localparam logic [DEV_W-1:0] WRAP_LIMIT = 32'h8000_0000;
    localparam logic [DEV_W-1:0] WRAP_MAX   = 32'hFFFF_FFFF;
    localparam logic [19:0]      NS_PER_MS  = 20'd1000000;
    // Largest extended millisecond count whose nanosecond value fits int64.
    localparam logic [NS_W-1:0]  EXT_MS_MAX = 64'd9223372036854;

    localparam logic REQ_MAP   = 1'b0;
    localparam logic REQ_RESET = 1'b1;

    localparam logic [ST_W-1:0] ST_MAPPED  = 2'd0;
    localparam logic [ST_W-1:0] ST_FIRST   = 2'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic                   req_type;
        logic [DEV_W-1:0]       device_ms;
        logic signed [NS_W-1:0] host_receive_ns;
    } t_req;

    typedef struct packed {
        logic                   started;
        logic [DEV_W-1:0]       last_device_ms;
        logic [DEV_W-1:0]       wrap_total;
        logic signed [NS_W-1:0] offset_ns;
        logic signed [NS_W-1:0] last_host_receive_ns;
        logic signed [NS_W-1:0] last_sample_ns;
        logic                   reset_flag;
    } t_state;

    typedef struct packed {
        logic [ST_W-1:0]        status;
        logic signed [NS_W-1:0] sample_host_ns;
    } t_result;

endpackage

### hdl/tswo_calc.sv
// ----------------------------------------------------------------------------
// Timestamp mapping step
// Computes the next mapper state and the result for one request.
// ----------------------------------------------------------------------------
module tswo_calc (
    input  tswo_pkg::t_state  i_state,
    input  tswo_pkg::t_req    i_req,
    output tswo_pkg::t_state  o_state,
    output logic              o_emit,
    output tswo_pkg::t_result o_result
);
    import tswo_pkg::*;

    logic signed [NS_W-1:0] host;
    logic                   bad_host;
    logic                   dev_back;
    logic [DEV_W-1:0]       back;
    logic                   wrap_ev;
    logic                   short_back;
    logic [DEV_W-1:0]       wrap_new;
    logic [NS_W-1:0]        ext_ms;
    logic                   scale_ovf;
    logic [NS_W-1:0]        dev_ns;
    logic signed [NS_W-1:0] host_minus_dev;
    logic signed [NS_W-1:0] off_base;
    logic [NS_W:0]          sum;
    logic                   sum_ovf;
    logic signed [NS_W-1:0] mapped_raw;
    logic                   clamp;
    logic signed [NS_W-1:0] mapped;
    logic signed [NS_W-1:0] off_new;
    logic                   back_sample;

    assign host       = $signed(i_req.host_receive_ns);
    assign bad_host   = (host <= 0) ||
                        (i_state.started && (host < $signed(i_state.last_host_receive_ns)));
    assign dev_back   = i_state.started && (i_req.device_ms < i_state.last_device_ms);
    assign back       = i_state.last_device_ms - i_req.device_ms;
    assign wrap_ev    = dev_back && (back > WRAP_LIMIT);
    assign short_back = dev_back && !wrap_ev;
    assign wrap_new   = (wrap_ev && (i_state.wrap_total != WRAP_MAX)) ?
                        i_state.wrap_total + 1'b1 : i_state.wrap_total;

    assign ext_ms    = {wrap_new, i_req.device_ms};
    assign scale_ovf = ext_ms > EXT_MS_MAX;
    assign dev_ns    = ext_ms[EXT_MS_W-1:0] * NS_PER_MS;

    assign host_minus_dev = host - $signed(dev_ns);
    assign off_base = i_state.started ? $signed(i_state.offset_ns) : host_minus_dev;
    assign sum      = {off_base[NS_W-1], off_base} + {1'b0, dev_ns};
    assign sum_ovf  = sum[NS_W] != sum[NS_W-1];
    assign mapped_raw = $signed(sum[NS_W-1:0]);
    assign clamp    = mapped_raw > host;
    assign mapped   = clamp ? host : mapped_raw;
    assign off_new  = clamp ? host_minus_dev : off_base;
    assign back_sample = i_state.started && (mapped < $signed(i_state.last_sample_ns));

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b1;
        o_result = '{status: ST_INVALID, sample_host_ns: '0};
        if (i_req.req_type == REQ_RESET) begin
            o_state            = '0;
            o_state.reset_flag = 1'b1;
            o_emit             = 1'b0;
        end else if (!bad_host && !short_back) begin
            o_state.wrap_total = wrap_new;
            if (!scale_ovf) begin
                o_state.offset_ns = off_base;
                if (!sum_ovf) begin
                    o_state.offset_ns = off_new;
                    if (!back_sample) begin
                        o_state.started              = 1'b1;
                        o_state.last_device_ms       = i_req.device_ms;
                        o_state.last_host_receive_ns = host;
                        o_state.last_sample_ns       = mapped;
                        o_state.reset_flag           = 1'b0;
                        o_result.status = i_state.reset_flag ? ST_FIRST : ST_MAPPED;
                        o_result.sample_host_ns = mapped;
                    end
                end
            end
        end
    end

endmodule

### hdl/timestamp_wrap_offset_mapper.sv
// ----------------------------------------------------------------------------
// Timestamp wrap offset mapper
// Maps 32-bit millisecond device timestamps onto the host nanosecond clock.
// ----------------------------------------------------------------------------
// Requests enter on the s channel: tuser carries the request type (map or
// reset), tdata carries device_ms in bits 31:0 and host_receive_ns in 95:32.
// Each map request yields one result on the m channel: tuser carries the
// status (mapped, first after reset, invalid), tdata the mapped host time.
// A reset request clears the mapper state and yields no result.
// A request is captured in an input register and evaluated from there as
// soon as the output register can take its result; the mapper state and
// the result register are written at the same edge. One request per cycle is
// sustained while the receiver takes the results; the combinational state
// update (wrap extension, scale by 1e6 and offset add) bounds the evaluation.
// When the receiver stalls, a result waits in the output register while the
// next request is held in the input register; requests are refused only
// when both registers are full. Reset requests pass even during a stall.
// After i_rst_n the channels are empty and the mapper is not started.
// ----------------------------------------------------------------------------
module timestamp_wrap_offset_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // device_ms, host_receive_ns
    input  logic        i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // sample_host_ns
    output logic [1:0]  o_m_tuser    // status
);
    import tswo_pkg::*;

    t_req    r_in;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    n_emit;
    logic    advance;

    tswo_calc u_calc (
        .i_state  (r_state),
        .i_req    (r_in),
        .o_state  (n_state),
        .o_emit   (n_emit),
        .o_result (n_out)
    );

    assign advance    = r_in_valid && ((r_in.req_type == REQ_RESET) ||
                                       !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.req_type        <= i_s_tuser;
            r_in.device_ms       <= i_s_tdata[31:0];
            r_in.host_receive_ns <= i_s_tdata[95:32];
        end
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.sample_host_ns;
    assign o_m_tuser  = r_out.status;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_INVALID)) |-> (o_m_tdata == '0))
        else $error("Invalid result carries a nonzero sample.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == ST_MAPPED) || (o_m_tuser == ST_FIRST) ||
                        (o_m_tuser == ST_INVALID)))
        else $error("Result status is not a defined code.");

    a_sample_le_host: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.started |->
            ($signed(r_state.last_sample_ns) <= $signed(r_state.last_host_receive_ns)))
        else $error("Last sample exceeds last receive time.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid))
        else $error("Input refused while a register is free.");

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in.req_type == REQ_RESET)) |=>
            (!r_state.started && r_state.reset_flag && (r_state.wrap_total == '0)))
        else $error("Reset request did not clear the mapper state.");
`endif

endmodule
